[hdl/cwhist_pkg.sv]
// Package for the codeword histogram builder: sizes, request and result codes.
// No dependencies.
package cwhist_pkg;
    localparam int MAX_WORDS_DEF  = 256;
    localparam int MAX_CHUNKS_DEF = 16;
    localparam int LANES_DEF      = 8;
    localparam int ELEM_W         = 8;
    localparam int DIST_W         = 23;
    localparam int COUNT_W        = 16;
    localparam logic [DIST_W-1:0]  DIST_SAT  = '1;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    typedef enum logic [1:0] {
        REQ_WRITE_WORD = 2'd0,
        REQ_DESC_CHUNK = 2'd1,
        REQ_READ_BIN   = 2'd2,
        REQ_CLEAR      = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        RES_ACK   = 2'd0,
        RES_CLASS = 2'd1,
        RES_BIN   = 2'd2
    } t_res;

    localparam logic CFG_WORDS  = 1'b0;
    localparam logic CFG_CHUNKS = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] word_index;
        logic [3:0] chunk_index;
        logic [7:0] elem0;
        logic [7:0] elem1;
        logic [7:0] elem2;
        logic [7:0] elem3;
        logic [7:0] elem4;
        logic [7:0] elem5;
        logic [7:0] elem6;
        logic [7:0] elem7;
    } t_in;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  best_word;
        logic [22:0] best_distance;
        logic [15:0] bin_count;
    } t_out;
endpackage

[hdl/cwhist_if.sv]
// Valid/ready channel carrying one request or result payload.
// Depends on cwhist_pkg for the payload types.
interface cwhist_in_if;
    logic valid;
    logic ready;
    cwhist_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cwhist_out_if;
    logic valid;
    logic ready;
    cwhist_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/cwhist_lane.sv]
// One distance lane: squared difference of one element pair, registered.
// Depends on cwhist_pkg.
module cwhist_lane (
    input  logic        i_clk,
    input  logic [7:0]  i_a,
    input  logic [7:0]  i_b,
    output logic [15:0] o_sq
);
    import cwhist_pkg::*;
    logic [7:0]  w_d;
    logic [15:0] r_sq;
    assign w_d = (i_a > i_b) ? i_a - i_b : i_b - i_a;
    always_ff @(posedge i_clk) begin
        r_sq <= w_d * w_d;
    end
    assign o_sq = r_sq;
endmodule

[hdl/cwhist_merge.sv]
// Merge stage: sums the lane squares of one chunk into a chunk distance.
// Depends on cwhist_pkg.
module cwhist_merge #(
    parameter int LANES = cwhist_pkg::LANES_DEF
) (
    input  logic                     i_clk,
    input  logic [LANES-1:0][15:0]   i_sq,
    output logic [18:0]              o_sum
);
    import cwhist_pkg::*;
    logic [18:0] w_sum;
    logic [18:0] r_sum;
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < LANES; k++) w_sum = w_sum + 19'(i_sq[k]);
    end
    always_ff @(posedge i_clk) begin
        r_sum <= w_sum;
    end
    assign o_sum = r_sum;
endmodule

[hdl/codeword_histogram_builder.sv]
// Channel   Dir  Payload
// in        in   req_type, word_index, chunk_index, elem0..elem7
// out       out  result_kind, best_word, best_distance, bin_count
// cfg       in   write enable, index, 9-bit data
// After acceptance a write or plain descriptor chunk passes through S_OUT before its result
// is offered, and a bin read through S_RDBIN and S_OUT. The last chunk adds a search over
// words*chunks reads (one codebook memory read a cycle), then the drain and update states.
// A clear sweeps MAX_WORDS bins. The input opens in the cycle after the result is taken.
// Reset is synchronous, active low; after it a clearing pass over all MAX_WORDS bins
// holds ready low. A result waits in an output register and blocks the input.
// Depends on cwhist_pkg, cwhist_if, cwhist_lane and cwhist_merge.
module codeword_histogram_builder #(
    parameter int MAX_WORDS  = cwhist_pkg::MAX_WORDS_DEF,
    parameter int MAX_CHUNKS = cwhist_pkg::MAX_CHUNKS_DEF,
    parameter int LANES      = cwhist_pkg::LANES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cwhist_in_if.sink  in_ch,
    cwhist_out_if.source out_ch,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [8:0] i_cfg_data
);
    import cwhist_pkg::*;
    localparam int WW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int AW  = WW + CW;
    localparam int CH_W = LANES * ELEM_W;
    localparam int SUM_W = 19 + CW + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_UPD   = 7'b0001000,
        S_RDBIN = 7'b0010000,
        S_CLR   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CH_W-1:0] r_cb [2**AW];
    logic [CH_W-1:0] r_desc [MAX_CHUNKS];
    logic [COUNT_W-1:0] r_hist [MAX_WORDS];
    logic [8:0] r_words;
    logic [4:0] r_chunks;
    logic [WW:0] r_w;
    logic [CW:0] r_c;
    logic [WW-1:0] r_word_p [3];
    logic [2:0] r_v, r_last;
    logic [CH_W-1:0] r_cb_q, r_desc_q;
    logic [SUM_W-1:0] r_acc, r_best;
    logic [WW-1:0] r_best_w;
    logic r_have;
    logic r_init;
    logic [WW-1:0] r_addr;
    logic [COUNT_W-1:0] r_hq;
    logic r_oob;
    t_out r_out;
    logic r_ovalid;
    logic [LANES-1:0][15:0] w_sq;
    logic [18:0] w_csum;
    logic [8:0] w_nw;
    logic [4:0] w_nc;
    logic [CH_W-1:0] w_pack;
    logic w_acc_in;
    t_in w_d;
    logic [7:0] w_el [8];

    assign w_d = in_ch.data;
    assign w_el = '{w_d.elem0, w_d.elem1, w_d.elem2, w_d.elem3,
                    w_d.elem4, w_d.elem5, w_d.elem6, w_d.elem7};
    always_comb begin
        for (int k = 0; k < LANES; k++) w_pack[k*ELEM_W +: ELEM_W] = w_el[k];
    end
    assign w_nw = (r_words == 9'd0) ? 9'd1 :
                  (32'(r_words) > MAX_WORDS) ? 9'(MAX_WORDS) : r_words;
    assign w_nc = (r_chunks == 5'd0) ? 5'd1 :
                  (32'(r_chunks) > MAX_CHUNKS) ? 5'(MAX_CHUNKS) : r_chunks;

    assign in_ch.ready = (r_state == S_IDLE) && !r_ovalid;
    assign w_acc_in = in_ch.valid && in_ch.ready;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= 9'd256;
            r_chunks <= 5'd16;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_WORDS) r_words <= i_cfg_data;
            else r_chunks <= i_cfg_data[4:0];
        end
    end

    // Codebook and descriptor memories.
    always_ff @(posedge i_clk) begin
        if (w_acc_in && w_d.req_type == REQ_WRITE_WORD &&
            32'(w_d.word_index) < MAX_WORDS && 32'(w_d.chunk_index) < MAX_CHUNKS)
            r_cb[{WW'(w_d.word_index), CW'(w_d.chunk_index)}] <= w_pack;
        r_cb_q <= r_cb[{r_w[WW-1:0], r_c[CW-1:0]}];
    end
    always_ff @(posedge i_clk) begin
        if (w_acc_in && w_d.req_type == REQ_DESC_CHUNK &&
            32'(w_d.chunk_index) < MAX_CHUNKS)
            r_desc[CW'(w_d.chunk_index)] <= w_pack;
        r_desc_q <= r_desc[r_c[CW-1:0]];
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        cwhist_lane u_lane (
            .i_clk(i_clk),
            .i_a(r_cb_q[g*ELEM_W +: ELEM_W]),
            .i_b(r_desc_q[g*ELEM_W +: ELEM_W]),
            .o_sq(w_sq[g])
        );
    end
    cwhist_merge #(.LANES(LANES)) u_merge (.i_clk(i_clk), .i_sq(w_sq), .o_sum(w_csum));

    // Histogram memory: one port, read registered. A bin read is addressed while
    // the request is accepted; the update reads and writes the winning bin.
    logic w_hwe;
    logic [WW-1:0] w_ha;
    logic [COUNT_W-1:0] w_hd;
    always_comb begin
        w_hwe = 1'b0;
        w_ha = r_addr;
        w_hd = '0;
        if (r_state == S_CLR) begin
            w_hwe = 1'b1;
            w_ha = r_w[WW-1:0];
        end else if (r_state == S_IDLE) begin
            w_ha = WW'(w_d.word_index);
        end else if (r_state == S_DRAIN) begin
            w_ha = r_best_w;
        end else if (r_state == S_UPD) begin
            w_ha = r_best_w;
            w_hwe = r_have && (r_hq != COUNT_SAT);
            w_hd = r_hq + 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_hwe) r_hist[w_ha] <= w_hd;
        r_hq <= r_hist[w_ha];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    case (w_d.req_type)
                        REQ_WRITE_WORD: n_state = S_OUT;
                        REQ_DESC_CHUNK: n_state = (5'(w_d.chunk_index) == w_nc - 5'd1)
                                                  ? S_SRCH : S_OUT;
                        REQ_READ_BIN: n_state = S_RDBIN;
                        REQ_CLEAR: n_state = S_CLR;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_SRCH: if (10'(r_w) == 10'(w_nw) - 10'd1 &&
                        6'(r_c) == 6'(w_nc) - 6'd1) n_state = S_DRAIN;
            S_DRAIN: if (!(|r_v) && !r_have) n_state = S_UPD;
            S_UPD: n_state = S_OUT;
            S_RDBIN: n_state = S_OUT;
            // The pass after reset returns to idle without a result.
            S_CLR: if (32'(r_w) == MAX_WORDS - 1) n_state = r_init ? S_IDLE : S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Search pipeline: addr -> mem read -> lanes -> merge -> accumulate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init <= 1'b1;
            r_ovalid <= 1'b0;
            r_w <= '0;
            r_c <= '0;
            r_v <= '0;
            r_last <= '0;
            r_have <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR && n_state != S_CLR) r_init <= 1'b0;
            if (r_ovalid && out_ch.ready) r_ovalid <= 1'b0;
            r_have <= (r_state == S_DRAIN) && !(|r_v);
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_w <= '0;
                        r_c <= '0;
                        r_addr <= WW'(w_d.word_index);
                        r_oob <= 32'(w_d.word_index) >= MAX_WORDS;
                        r_best <= '1;
                        r_best_w <= '0;
                        r_acc <= '0;
                        r_out <= '0;
                    end
                end
                S_SRCH: begin
                    if (6'(r_c) == 6'(w_nc) - 6'd1) begin
                        r_c <= '0;
                        r_w <= r_w + 1'b1;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_CLR: r_w <= r_w + 1'b1;
                S_UPD: begin
                    r_out.result_kind <= RES_CLASS;
                    r_out.best_word <= 8'(r_best_w);
                    r_out.best_distance <= (r_best > SUM_W'(DIST_SAT)) ? DIST_SAT
                                           : DIST_W'(r_best);
                    r_out.bin_count <= (r_hq == COUNT_SAT) ? r_hq : r_hq + 1'b1;
                end
                S_RDBIN: begin
                    r_out.result_kind <= RES_BIN;
                    r_out.bin_count <= r_oob ? '0 : r_hq;
                end
                S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
            // Stage flags: v[0] read data, v[1] lane reg, v[2] chunk sum ready.
            r_v <= {r_v[1:0], r_state == S_SRCH};
            r_last <= {r_last[1:0], 6'(r_c) == 6'(w_nc) - 6'd1};
            r_word_p[0] <= r_w[WW-1:0];
            r_word_p[1] <= r_word_p[0];
            r_word_p[2] <= r_word_p[1];
            if (r_v[2]) begin
                if (r_last[2]) begin
                    r_acc <= '0;
                    // Strict less-than keeps the lower index on a tie.
                    if ((r_acc + SUM_W'(w_csum)) < r_best) begin
                        r_best <= r_acc + SUM_W'(w_csum);
                        r_best_w <= r_word_p[2];
                    end
                end else begin
                    r_acc <= r_acc + SUM_W'(w_csum);
                end
            end
        end
    end
endmodule

[tb/cwhist_checker.sv]
`timescale 1ns / 1ps
// Checker for the codeword histogram builder: watches the request, result and
// configuration ports, predicts every result and compares it in order.
// Depends on cwhist_pkg and the channel interfaces in cwhist_if.
module cwhist_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cwhist_in_if       in_ch,
    cwhist_out_if      out_ch,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [8:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_classified,
    output int         o_bins_read
);
    import cwhist_pkg::*;

    logic [63:0] codebook [0:255][0:15];
    logic [63:0] desc_buf [0:15];
    logic [15:0] hist [0:256-1];
    logic [8:0]  words_reg;
    logic [4:0]  chunks_reg;
    t_out        exp_fifo [0:63];
    int          exp_wr;
    int          exp_rd;
    int          fails;
    int          classified;
    int          bins_read;

    function automatic logic [63:0] pack_chunk(t_in r);
        return {r.elem7, r.elem6, r.elem5, r.elem4, r.elem3, r.elem2, r.elem1, r.elem0};
    endfunction

    function automatic int unsigned chunk_sq_dist(logic [63:0] a, logic [63:0] b);
        int unsigned s;
        int x, y;
        s = 0;
        for (int k = 0; k < LANES_DEF; k++) begin
            x = int'(a[8*k +: 8]);
            y = int'(b[8*k +: 8]);
            s += 32'((x - y) * (x - y));
        end
        return s;
    endfunction

    // Applies one request to the shadow state and returns the result it causes.
    task automatic apply_request(input t_in r, output t_out e);
        int unsigned nw, nc, best_d, d;
        int best;
        e = '0;
        case (t_req'(r.req_type))
            REQ_WRITE_WORD: codebook[r.word_index][r.chunk_index] = pack_chunk(r);
            REQ_DESC_CHUNK: begin
                nw = 32'(words_reg);
                nc = 32'(chunks_reg);
                if (nw < 1) nw = 1;
                if (nw > MAX_WORDS_DEF) nw = MAX_WORDS_DEF;
                if (nc < 1) nc = 1;
                if (nc > MAX_CHUNKS_DEF) nc = MAX_CHUNKS_DEF;
                desc_buf[r.chunk_index] = pack_chunk(r);
                if (r.chunk_index == nc - 1) begin
                    best = 0;
                    best_d = 0;
                    for (int w = 0; w < nw; w++) begin
                        d = 0;
                        for (int c = 0; c < nc; c++)
                            d += chunk_sq_dist(desc_buf[c], codebook[w][c]);
                        // Strict less-than keeps the lower index on a tie.
                        if (w == 0 || d < best_d) begin
                            best_d = d;
                            best = w;
                        end
                    end
                    if (hist[best] != COUNT_SAT) hist[best] = hist[best] + 1'b1;
                    e.result_kind   = RES_CLASS;
                    e.best_word     = best[7:0];
                    e.best_distance = (best_d > DIST_SAT) ? DIST_SAT : best_d[22:0];
                    e.bin_count     = hist[best];
                end
            end
            REQ_READ_BIN: begin
                e.result_kind = RES_BIN;
                e.bin_count   = hist[r.word_index];
            end
            default: for (int w = 0; w < MAX_WORDS_DEF; w++) hist[w] = '0;
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_out e, got;
        if (!i_rst_n) begin
            for (int w = 0; w < MAX_WORDS_DEF; w++) hist[w] = '0;
            words_reg  = 9'd256;
            chunks_reg = 5'd16;
            exp_wr     = 0;
            exp_rd     = 0;
            fails      = 0;
            classified = 0;
            bins_read  = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WORDS) words_reg = i_cfg_data;
                else chunks_reg = i_cfg_data[4:0];
            end
            if (in_ch.valid && in_ch.ready) begin
                apply_request(in_ch.data, e);
                exp_fifo[exp_wr[5:0]] = e;
                exp_wr++;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (exp_wr == exp_rd) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result with nothing expected: kind %0d word %0d dist %0d count %0d",
                                 $realtime, got.result_kind, got.best_word,
                                 got.best_distance, got.bin_count);
                end else begin
                    e = exp_fifo[exp_rd[5:0]];
                    exp_rd++;
                    if (e.result_kind == RES_CLASS) classified++;
                    if (e.result_kind == RES_BIN) bins_read++;
                    if (got.result_kind != e.result_kind || got.best_word != e.best_word ||
                        got.best_distance != e.best_distance ||
                        got.bin_count != e.bin_count) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: mismatch: expected kind %0d word %0d dist %0d ",
                                      "count %0d, got kind %0d word %0d dist %0d count %0d"},
                                     $realtime, e.result_kind, e.best_word, e.best_distance,
                                     e.bin_count, got.result_kind, got.best_word,
                                     got.best_distance, got.bin_count);
                    end
                end
            end
        end
        o_pending    <= exp_wr - exp_rd;
        o_fail_count <= fails;
        o_classified <= classified;
        o_bins_read  <= bins_read;
    end
endmodule

[tb/tb_codeword_histogram_builder.sv]
`timescale 1ns / 1ps
// Top of the codeword histogram builder testbench: clock, reset, stimulus,
// configuration phases and verdict. Depends on cwhist_pkg, cwhist_if,
// cwhist_checker and the block itself.
module tb_codeword_histogram_builder;
    import cwhist_pkg::*;

    localparam int MODE_NONE = 0;
    localparam int MODE_SEND = 1;
    localparam int MODE_RECV = 2;
    localparam int MODE_BOTH = 3;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [8:0] i_cfg_data;
    int         fail_count, pending, classified, bins_read;

    cwhist_in_if  in_ch ();
    cwhist_out_if out_ch ();

    codeword_histogram_builder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    cwhist_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_classified(classified),
        .o_bins_read (bins_read)
    );

    bit cb_written [0:255][0:15];
    bit desc_written [0:15];
    int words_eff, chunks_eff;
    int idle_mode;
    int hold_seq;
    int sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("codeword_histogram_builder verification failed");
        $finish;
    end

    // Result side: random stalls per mode, plus a long hold-off on request.
    initial begin
        int left, last;
        left = 0;
        last = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != last) begin
                last = hold_seq;
                left = 600;
            end
            if (left > 0) begin
                left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (idle_mode)
                    MODE_RECV: out_ch.ready <= ($urandom_range(99) >= 64);
                    MODE_BOTH: out_ch.ready <= ($urandom_range(99) >= 31);
                    default:   out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    function automatic bit sender_idles();
        if (idle_mode == MODE_SEND) return $urandom_range(99) < 64;
        if (idle_mode == MODE_BOTH) return $urandom_range(99) < 31;
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_elem();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_in make_req(t_req kind, int word, int chunk);
        t_in r;
        r = '0;
        r.req_type    = kind;
        r.word_index  = 8'(word);
        r.chunk_index = 4'(chunk);
        r.elem0 = pick_elem(); r.elem1 = pick_elem(); r.elem2 = pick_elem();
        r.elem3 = pick_elem(); r.elem4 = pick_elem(); r.elem5 = pick_elem();
        r.elem6 = pick_elem(); r.elem7 = pick_elem();
        return r;
    endfunction

    function automatic t_in fill_req(t_req kind, int word, int chunk, logic [7:0] v);
        t_in r;
        r = make_req(kind, word, chunk);
        {r.elem0, r.elem1, r.elem2, r.elem3, r.elem4, r.elem5, r.elem6, r.elem7} = {8{v}};
        return r;
    endfunction

    task automatic send_req(input t_in r);
        if (sender_idles()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while (sender_idles()) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= r;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (r.req_type == REQ_WRITE_WORD) cb_written[r.word_index][r.chunk_index] = 1'b1;
        if (r.req_type == REQ_DESC_CHUNK) desc_written[r.chunk_index] = 1'b1;
        sent++;
    endtask

    // Stops offering requests until every expected result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_config(input int words, input int chunks);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WORDS;
        i_cfg_data  <= 9'(words);
        @(posedge i_clk);
        i_cfg_index <= CFG_CHUNKS;
        i_cfg_data  <= 9'(chunks);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        words_eff  = (words < 1) ? 1 : (words > MAX_WORDS_DEF) ? MAX_WORDS_DEF : words;
        chunks_eff = (chunks % 32 < 1) ? 1 :
                     (chunks % 32 > MAX_CHUNKS_DEF) ? MAX_CHUNKS_DEF : chunks % 32;
    endtask

    // Writes every codebook chunk the search will read that is not yet written; paired
    // words get equal contents when asked, which forces distance ties.
    task automatic fill_codebook(input bit ties);
        for (int w = 0; w < words_eff; w++)
            for (int c = 0; c < chunks_eff; c++)
                if (!cb_written[w][c])
                    send_req(ties ? fill_req(REQ_WRITE_WORD, w, c, 8'(w >> 1))
                                  : make_req(REQ_WRITE_WORD, w, c));
    endtask

    function automatic bit lower_chunks_written();
        for (int c = 0; c < chunks_eff - 1; c++)
            if (!desc_written[c]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic random_traffic(input int budget);
        int start, sel, idx;
        start = sent;
        while (sent - start < budget) begin
            sel = $urandom_range(99);
            if (sel < 55) begin
                for (int c = 0; c < chunks_eff; c++)
                    send_req(make_req(REQ_DESC_CHUNK, $urandom_range(255), c));
            end else if (sel < 70) begin
                send_req(make_req(REQ_WRITE_WORD, $urandom_range(255), $urandom_range(15)));
            end else if (sel < 88) begin
                send_req(make_req(REQ_READ_BIN, $urandom_range(255), $urandom_range(15)));
            end else if (sel < 92) begin
                send_req(make_req(REQ_CLEAR, $urandom_range(255), $urandom_range(15)));
            end else begin
                // A stray descriptor chunk; it may only finish a descriptor
                // whose lower chunks have all been sent.
                idx = $urandom_range(15);
                if (idx == chunks_eff - 1 && !lower_chunks_written()) idx = 0;
                send_req(make_req(REQ_DESC_CHUNK, $urandom_range(255), idx));
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_WORDS;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        idle_mode    = MODE_NONE;
        hold_seq     = 0;
        sent         = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero register values clamp up, out-of-range ones clamp down.
        set_config(0, 31);
        for (int c = 0; c < chunks_eff; c++) send_req(fill_req(REQ_WRITE_WORD, 0, c, 8'd0));
        for (int c = 0; c < chunks_eff; c++)
            send_req(fill_req(REQ_DESC_CHUNK, 255, c, 8'd255));  // largest distance
        send_req(fill_req(REQ_DESC_CHUNK, 0, 15, 8'd0));          // rerun, distance changes
        send_req(make_req(REQ_READ_BIN, 0, 0));
        send_req(make_req(REQ_READ_BIN, 255, 15));
        send_req(make_req(REQ_CLEAR, 0, 0));
        send_req(make_req(REQ_READ_BIN, 0, 0));
        send_req(fill_req(REQ_WRITE_WORD, 255, 15, 8'd255));
        send_req(make_req(REQ_DESC_CHUNK, 0, 3));
        random_traffic(60);

        set_config(511, 0);
        idle_mode = MODE_SEND;
        fill_codebook(1'b1);
        random_traffic(110);

        set_config(4, 3);
        idle_mode = MODE_RECV;
        fill_codebook(1'b0);
        hold_seq++;
        random_traffic(110);

        set_config(17, 2);
        idle_mode = MODE_BOTH;
        fill_codebook(1'b0);
        random_traffic(110);

        set_config(2, 5);
        idle_mode = MODE_NONE;
        fill_codebook(1'b0);
        random_traffic(110);

        set_config(256, 1);
        idle_mode = MODE_RECV;
        random_traffic(110);

        drain();
        $display("Sent %0d requests over six register settings; %0d descriptors classified,",
                 sent, classified);
        $display("%0d bins read, mismatches %0d.", bins_read, fail_count);
        if (fail_count == 0)
            $display("codeword_histogram_builder verification clean");
        else
            $display("codeword_histogram_builder verification failed");
        $finish;
    end
endmodule

[codeword_histogram_builder.f]
hdl/cwhist_pkg.sv
hdl/cwhist_if.sv
hdl/cwhist_lane.sv
hdl/cwhist_merge.sv
hdl/codeword_histogram_builder.sv
tb/cwhist_checker.sv
tb/tb_codeword_histogram_builder.sv
